// ===== design/clp_pkg.sv =====
// Shared constants and types for the CIE 1931 lightness to PWM level block.
// No dependencies; used by the channel interfaces and the top level.
package clp_pkg;

    localparam int INDEX_BITS_DEF  = 16;
    localparam int PERIOD_BITS_DEF = 32;
    localparam int DUTY_BITS       = 32;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 3;

    localparam logic [0:0] REG_PWM_PERIOD = 1'b0;

    localparam logic [31:0] PERIOD_RESET = 32'd65535;

    localparam int LSCALE   = 10000;
    localparam int DIV_BITS = 14;
    localparam int Y_BITS   = 14;

    localparam logic [13:0] LIN_LIMIT   = 14'd800;
    localparam logic [19:0] LIN_MUL     = 20'd1000;
    localparam logic [19:0] LIN_BIAS    = 20'd4511;
    localparam logic [20:0] CUB_MUL     = 21'd100;
    localparam logic [20:0] CUB_BIAS    = 21'd160000;
    localparam logic [41:0] CUBE_BIAS   = 42'd50000000;
    localparam logic [30:0] DUTY_BIAS   = 31'd5000;
    localparam logic [30:0] DUTY_SCALE  = 31'd10000;

    localparam logic [20:0] RCP_LIN  = 21'd1904009;
    localparam int          SH_LIN   = 34;
    localparam logic [21:0] RCP_CUB  = 22'd2314099;
    localparam int          SH_CUB   = 28;
    localparam logic [32:0] RCP_Y    = 33'd5764607524;
    localparam int          SH_Y     = 51;
    localparam logic [31:0] RCP_DUTY = 32'd3518437209;
    localparam int          SH_DUTY  = 45;

    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'b001,
        SEQ_COUNT = 3'b010,
        SEQ_DIV   = 3'b100
    } seq_state_t;

endpackage

// ===== design/clp_if.sv =====
// Valid/ready channel interfaces for level requests and duty results.
// Depends on clp_pkg for the default index width and the result width.
interface clp_level_if #(
    parameter int INDEX_BITS = clp_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] level_index;

    modport source (output valid, output level_index, input ready);
    modport sink   (input valid, input level_index, output ready);
endinterface

interface clp_duty_if;
    logic                           valid;
    logic                           ready;
    logic [clp_pkg::DUTY_BITS-1:0]  duty_value;
    logic                           index_out_of_range;

    modport source (output valid, output duty_value, output index_out_of_range, input ready);
    modport sink   (input valid, input duty_value, input index_out_of_range, output ready);
endinterface

// ===== design/cie_lightness_pwm_level.sv =====
// CIE 1931 lightness to PWM duty, one level per beat, fully pipelined.
// Depends on clp_pkg and the channel interfaces in clp_if.sv.
//
// Usage: the APB port holds pwm_period (byte address 0). A write starts a
// level-count sequencer: a popcount state, then a bit-serial divide. While
// it runs level_in.ready stays low; the same sequence runs right after reset
// (period 65535), so the first beat is taken only after it has finished.
// level_in carries a level_index beat; duty_out returns duty_value and
// index_out_of_range for it, in order. Each beat passes through 28 register
// stages: one input stage, 14 restoring-divide stages for the lightness, then
// 13 stages of reciprocal multiplies for the curve and the period scaling.
// One beat is taken per cycle while the sequencer is idle and nothing stalls.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stall on duty_out fills the bubbles first and only
// then drops level_in.ready; no beat is lost or repeated. The user must write
// configuration only while no beat is in flight; the block does not enforce it.
module cie_lightness_pwm_level #(
    parameter int INDEX_BITS  = clp_pkg::INDEX_BITS_DEF,
    parameter int PERIOD_BITS = clp_pkg::PERIOD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [clp_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [clp_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    clp_level_if.sink                         level_in,
    clp_duty_if.source                        duty_out
);

    localparam int DB  = clp_pkg::DIV_BITS;
    localparam int YW  = clp_pkg::Y_BITS;
    localparam int NW  = INDEX_BITS + DB;
    localparam int DW  = (NW > PERIOD_BITS + DB) ? NW : PERIOD_BITS + DB;
    localparam int CW  = (INDEX_BITS > PERIOD_BITS) ? INDEX_BITS : PERIOD_BITS;
    localparam int LW  = PERIOD_BITS + 1;
    localparam int OW  = $clog2(PERIOD_BITS + 1);
    localparam int TW  = $clog2(LW + 1);
    localparam int S_A = DB + 1;
    localparam int S_B = S_A + 1;
    localparam int S_C = S_B + 1;
    localparam int S_D = S_C + 1;
    localparam int S_E = S_D + 1;
    localparam int S_F = S_E + 1;
    localparam int S_G = S_F + 1;
    localparam int S_H = S_G + 1;
    localparam int S_I = S_H + 1;
    localparam int S_J = S_I + 1;
    localparam int S_K = S_J + 1;
    localparam int S_L = S_K + 1;
    localparam int S_M = S_L + 1;
    localparam int NST = S_M + 1;

    // configuration and level-count sequencer
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] levels_reg, levels_next;
    logic [OW-1:0]          ones_reg, ones_next;
    logic [LW-1:0]          dvd_reg, dvd_next;
    logic [OW-1:0]          lrem_reg, lrem_next;
    logic [TW-1:0]          cnt_reg, cnt_next;
    clp_pkg::seq_state_t    state_reg, state_next;
    logic                   cfg_wr;
    logic [OW-1:0]          pop;
    logic [OW:0]            ltmp;
    logic                   lge;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[clp_pkg::APB_ADDR_BITS-1] == clp_pkg::REG_PWM_PERIOD);
    assign prdata = (paddr[clp_pkg::APB_ADDR_BITS-1] == clp_pkg::REG_PWM_PERIOD)
                    ? clp_pkg::APB_DATA_BITS'(period_reg) : '0;

    always_comb
    begin
        pop = '0;
        for (int i = 0; i < PERIOD_BITS; i++)
        begin
            pop = pop + OW'(period_reg[i]);
        end
    end

    assign ltmp = {lrem_reg, dvd_reg[LW-1]};
    assign lge  = ltmp >= {1'b0, ones_reg};

    always_comb
    begin
        state_next  = state_reg;
        levels_next = levels_reg;
        ones_next   = ones_reg;
        dvd_next    = dvd_reg;
        lrem_next   = lrem_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            clp_pkg::SEQ_IDLE:
            begin
            end
            clp_pkg::SEQ_COUNT:
            begin
                ones_next  = pop;
                dvd_next   = LW'(period_reg) + LW'(pop) - LW'(1);
                lrem_next  = '0;
                cnt_next   = '0;
                state_next = clp_pkg::SEQ_DIV;
            end
            clp_pkg::SEQ_DIV:
            begin
                lrem_next = lge ? OW'(ltmp - {1'b0, ones_reg}) : OW'(ltmp);
                dvd_next  = {dvd_reg[LW-2:0], lge};
                cnt_next  = cnt_reg + TW'(1);
                if (cnt_reg == TW'(LW - 1))
                begin
                    levels_next = (ones_reg == '0) ? '0 : dvd_next[PERIOD_BITS-1:0];
                    state_next  = clp_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = clp_pkg::SEQ_COUNT;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = clp_pkg::SEQ_COUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= clp_pkg::SEQ_COUNT;
            period_reg <= PERIOD_BITS'(clp_pkg::PERIOD_RESET);
            levels_reg <= '0;
            ones_reg   <= '0;
            dvd_reg    <= '0;
            lrem_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            levels_reg <= levels_next;
            ones_reg   <= ones_next;
            dvd_reg    <= dvd_next;
            lrem_reg   <= lrem_next;
            cnt_reg    <= cnt_next;
            if (cfg_wr)
            begin
                period_reg <= pwdata[PERIOD_BITS-1:0];
            end
        end
    end

    // pipeline control
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;
    logic [NST-1:0] oor_reg;
    logic           acc;

    always_comb
    begin
        en[NST] = duty_out.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign level_in.ready = en[0] && (state_reg == clp_pkg::SEQ_IDLE);
    assign acc            = level_in.valid && level_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= acc;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            oor_reg[0] <= CW'(level_in.level_index) >= CW'(levels_reg);
        end
        for (int k = 1; k < NST; k++)
        begin
            if (en[k])
            begin
                oor_reg[k] <= oor_reg[k-1];
            end
        end
    end

    // lightness: restoring divide, one quotient bit per stage
    logic [DW-1:0] rem_reg  [0:DB];
    logic [DB-1:0] quot_reg [0:DB];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= DW'(NW'(level_in.level_index) * NW'(clp_pkg::LSCALE));
            quot_reg[0] <= '0;
        end
    end

    for (genvar g = 1; g <= DB; g++)
    begin : g_div
        logic [DW-1:0] dsh;
        logic          ge;
        assign dsh = DW'(levels_reg) << (DB - g);
        assign ge  = rem_reg[g-1] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en[g])
            begin
                rem_reg[g]  <= ge ? rem_reg[g-1] - dsh : rem_reg[g-1];
                quot_reg[g] <= quot_reg[g-1] | (DB'(ge) << (DB - g));
            end
        end
    end

    // curve and period scaling
    logic          lin_a_reg, lin_b_reg, lin_c_reg, lin_d_reg, lin_e_reg, lin_f_reg;
    logic [19:0]   nlin_a_reg;
    logic [20:0]   ncub_a_reg;
    logic [40:0]   ylinp_b_reg;
    logic [42:0]   bp_b_reg;
    logic [YW-1:0] ylin_c_reg, ylin_d_reg, ylin_e_reg, ylin_f_reg;
    logic [13:0]   b_c_reg;
    logic [27:0]   b2_c_reg;
    logic [41:0]   cube_d_reg;
    logic [31:0]   n2_e_reg;
    logic [64:0]   yp_f_reg;
    logic [YW-1:0] y_g_reg;
    logic [30:0]   a_h_reg, a_i_reg, a_j_reg;
    logic [30:0]   bl_h_reg, bl_i_reg, bl_j_reg;
    logic [62:0]   qhp_i_reg;
    logic [15:0]   qh_j_reg, qh_k_reg, qh_l_reg;
    logic [30:0]   qm_j_reg;
    logic [30:0]   c_k_reg;
    logic [62:0]   qlp_l_reg;
    logic [31:0]   duty_m_reg;
    logic [31:0]   per32;
    logic [DB-1:0] light;

    assign per32 = 32'(period_reg);
    assign light = quot_reg[DB];

    always_ff @(posedge clk)
    begin
        if (en[S_A])
        begin
            lin_a_reg  <= light <= clp_pkg::LIN_LIMIT;
            nlin_a_reg <= 20'(light) * clp_pkg::LIN_MUL + clp_pkg::LIN_BIAS;
            ncub_a_reg <= 21'(light) * clp_pkg::CUB_MUL + clp_pkg::CUB_BIAS;
        end
        if (en[S_B])
        begin
            lin_b_reg   <= lin_a_reg;
            ylinp_b_reg <= 41'(nlin_a_reg) * 41'(clp_pkg::RCP_LIN);
            bp_b_reg    <= 43'(ncub_a_reg) * 43'(clp_pkg::RCP_CUB);
        end
        if (en[S_C])
        begin
            lin_c_reg  <= lin_b_reg;
            ylin_c_reg <= YW'(ylinp_b_reg >> clp_pkg::SH_LIN);
            b_c_reg    <= bp_b_reg[clp_pkg::SH_CUB +: 14];
            b2_c_reg   <= 28'(bp_b_reg[clp_pkg::SH_CUB +: 14])
                          * 28'(bp_b_reg[clp_pkg::SH_CUB +: 14]);
        end
        if (en[S_D])
        begin
            lin_d_reg  <= lin_c_reg;
            ylin_d_reg <= ylin_c_reg;
            cube_d_reg <= 42'(b2_c_reg) * 42'(b_c_reg);
        end
        if (en[S_E])
        begin
            lin_e_reg  <= lin_d_reg;
            ylin_e_reg <= ylin_d_reg;
            n2_e_reg   <= 32'((cube_d_reg + clp_pkg::CUBE_BIAS) >> 8);
        end
        if (en[S_F])
        begin
            lin_f_reg  <= lin_e_reg;
            ylin_f_reg <= ylin_e_reg;
            yp_f_reg   <= 65'(n2_e_reg) * 65'(clp_pkg::RCP_Y);
        end
        if (en[S_G])
        begin
            y_g_reg <= lin_f_reg ? ylin_f_reg : YW'(yp_f_reg >> clp_pkg::SH_Y);
        end
        if (en[S_H])
        begin
            a_h_reg  <= 31'(y_g_reg) * 31'(per32[31:16]);
            bl_h_reg <= 31'(y_g_reg) * 31'(per32[15:0]) + clp_pkg::DUTY_BIAS;
        end
        if (en[S_I])
        begin
            a_i_reg   <= a_h_reg;
            bl_i_reg  <= bl_h_reg;
            qhp_i_reg <= 63'(a_h_reg) * 63'(clp_pkg::RCP_DUTY);
        end
        if (en[S_J])
        begin
            a_j_reg  <= a_i_reg;
            bl_j_reg <= bl_i_reg;
            qh_j_reg <= 16'(qhp_i_reg >> clp_pkg::SH_DUTY);
            qm_j_reg <= 31'(16'(qhp_i_reg >> clp_pkg::SH_DUTY)) * clp_pkg::DUTY_SCALE;
        end
        if (en[S_K])
        begin
            qh_k_reg <= qh_j_reg;
            c_k_reg  <= ((a_j_reg - qm_j_reg) << 16) + bl_j_reg;
        end
        if (en[S_L])
        begin
            qh_l_reg  <= qh_k_reg;
            qlp_l_reg <= 63'(c_k_reg) * 63'(clp_pkg::RCP_DUTY);
        end
        if (en[S_M])
        begin
            duty_m_reg <= oor_reg[S_M-1] ? '0
                          : (32'(qh_l_reg) << 16) + 32'(qlp_l_reg >> clp_pkg::SH_DUTY);
        end
    end

    assign duty_out.valid              = v_reg[NST-1];
    assign duty_out.duty_value         = duty_m_reg;
    assign duty_out.index_out_of_range = oor_reg[NST-1];

endmodule

// ===== tb/tb_cie_lightness_pwm_level.sv =====
// Testbench for cie_lightness_pwm_level: APB period setup, level beats in, duty beats out.
// Predicts every duty result in-house and checks it field by field in order.
// Depends on clp_pkg, clp_if.sv and the block's top level.
module tb_cie_lightness_pwm_level;

    typedef struct packed {
        logic [31:0] duty;
        logic        oor;
    } duty_beat_t;

    localparam int QUIET_CYCLES  = 40;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int HOLD_OFF_LONG = 300;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [clp_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [clp_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [clp_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;

    clp_level_if level_ch ();
    clp_duty_if  duty_ch ();

    cie_lightness_pwm_level dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .level_in (level_ch.sink),
        .duty_out (duty_ch.source)
    );

    duty_beat_t  duty_expected[$];
    logic [31:0] cur_period;
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned level_count(logic [31:0] period);
        longint unsigned ones;
        ones = $countones(period);
        return (ones == 0) ? 0 : (longint'(period) + ones - 1) / ones;
    endfunction

    function automatic duty_beat_t predict_duty(logic [31:0] period, logic [15:0] idx);
        duty_beat_t      r;
        longint unsigned levels;
        longint unsigned light;
        longint unsigned m;
        longint unsigned b;
        longint unsigned y;
        levels = level_count(period);
        r.duty = '0;
        r.oor  = 1'b1;
        if (longint'(idx) < levels)
        begin
            light = (longint'(idx) * 10000) / levels;
            m = light * 100;
            if (m <= 80000)
                y = (m * 10 + 4511) / 9023;
            else
            begin
                b = (m + 160000) / 116;
                y = (b * b * b + 50000000) / 100000000;
            end
            r.duty = 32'((y * longint'(period) + 5000) / 10000);
            r.oor  = 1'b0;
        end
        return r;
    endfunction

    task automatic send_level(logic [15:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            level_ch.valid <= 1'b0;
            @(negedge clk);
        end
        level_ch.valid       <= 1'b1;
        level_ch.level_index <= idx;
        do @(posedge clk); while (!level_ch.ready);
        duty_expected.push_back(predict_duty(cur_period, idx));
        @(negedge clk);
    endtask

    task automatic stop_sending();
        level_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (duty_expected.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_period(logic [31:0] value);
        stop_sending();
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= clp_pkg::APB_ADDR_BITS'(clp_pkg::REG_PWM_PERIOD) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("period readback: expected %0d got %0d", value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_period = value;
    endtask

    function automatic logic [15:0] pick_level();
        longint unsigned lv;
        lv = level_count(cur_period);
        if ($urandom_range(99) < 20 || lv >= 65536)
            return 16'($urandom);
        return 16'($urandom_range(0, (lv + 2 > 65535) ? 65535 : int'(lv + 2)));
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(3))
            0: return $urandom_range(1, 64);
            1: return $urandom_range(1, 5000);
            2: return $urandom_range(1, 300000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_period();
        send_level(16'd0);
        send_level(16'd1);
        send_level(16'd4095);
        send_level(16'd4096);
        send_level(16'h5555);
        send_level(16'hAAAA);
        send_level(16'hFFFF);
    endtask

    task automatic test_extreme_periods();
        write_period(32'd1);
        send_level(16'd0);
        send_level(16'd1);
        write_period(32'd0);
        send_level(16'd0);
        send_level(16'hFFFF);
        write_period(32'hFFFF_FFFF);
        send_level(16'd0);
        send_level(16'd32768);
        send_level(16'hFFFF);
        write_period(32'd3);
        send_level(16'd0);
        send_level(16'd1);
        send_level(16'd2);
        write_period(32'h8000_0000);
        send_level(16'd1);
        send_level(16'hFFFF);
        write_period(32'd100);
        for (int i = 0; i < 36; i += 7)
            send_level(16'(i));
    endtask

    task automatic test_random_levels(int sidle, int ridle, int beats);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < beats; n++)
        begin
            if (n % 100 == 0)
                write_period(pick_period());
            send_level(pick_level());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_period(32'd65535);
        hold_off = HOLD_OFF_LONG;
        for (int n = 0; n < 80; n++)
            send_level(pick_level());
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++)
            send_level(pick_level());
        stop_sending();
        while (duty_expected.size() != 0)
            @(negedge clk);
        for (int n = 0; n < 20; n++)
            send_level(pick_level());
    endtask

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            duty_ch.ready <= 1'b0;
        end
        else
            duty_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && duty_ch.valid && duty_ch.ready)
        begin
            if (duty_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected duty beat: duty %0d oor %0b",
                             duty_ch.duty_value, duty_ch.index_out_of_range);
            end
            else
            begin
                duty_beat_t e;
                e = duty_expected.pop_front();
                if (duty_ch.duty_value !== e.duty || duty_ch.index_out_of_range !== e.oor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("duty mismatch: expected %0d/%0b got %0d/%0b",
                                 e.duty, e.oor, duty_ch.duty_value,
                                 duty_ch.index_out_of_range);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((level_ch.valid && level_ch.ready) || (duty_ch.valid && duty_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        level_ch.valid       = 1'b0;
        level_ch.level_index = '0;
        duty_ch.ready        = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 0;
        idle_cycles   = 0;
        cur_period    = clp_pkg::PERIOD_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_period();
        test_extreme_periods();
        test_random_levels(23, 65, 600);
        test_random_levels(65, 23, 600);
        test_random_levels(0, 0, 500);
        test_backpressure();
        test_drain_pause();

        stop_sending();
        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
design/clp_pkg.sv
design/clp_if.sv
design/cie_lightness_pwm_level.sv
tb/tb_cie_lightness_pwm_level.sv
